// ===== rtl/dscm_pkg.sv =====
// Package: shared constants and types for the delta sample channel mixer.
package dscm_pkg;

   localparam int CHANNELS_DEF    = 8;
   localparam int MEM_DEPTH_DEF   = 65536;
   localparam int DELTA_SHIFT_DEF = 4;
   localparam int MASK_BITS       = 8;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   localparam logic [1:0] OP_MEM_WRITE = 2'd0;
   localparam logic [1:0] OP_REG_WRITE = 2'd1;
   localparam logic [1:0] OP_RENDER    = 2'd2;

   localparam logic [3:0] REG_BASE      = 4'd0;
   localparam logic [3:0] REG_COUNT     = 4'd1;
   localparam logic [3:0] REG_LOOP_BEG  = 4'd2;
   localparam logic [3:0] REG_LOOP_END  = 4'd3;
   localparam logic [3:0] REG_LOOP_SMP  = 4'd4;
   localparam logic [3:0] REG_POSITION  = 4'd5;
   localparam logic [3:0] REG_LAST_SMP  = 4'd6;
   localparam logic [3:0] REG_VOLUME    = 4'd7;
   localparam logic [3:0] REG_FLAGS     = 4'd8;

   localparam int FLAG_LOOP = 0;
   localparam int FLAG_PLAY = 1;
   localparam int FLAG_MONO = 2;
   localparam int FLAG_LEFT = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAN,
      ST_READ,
      ST_MIX,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/delta_sample_channel_mixer.sv =====
// Top level: delta sample channel mixer with sample RAM and channel register file.
// Usage:
//   The req_ channel carries one command per beat: opcode 0 writes a sample
//   RAM word, opcode 1 writes one channel register, opcode 2 renders one
//   output sample for the given side. Only renders produce an rsp_ beat,
//   carrying the mixed sample, its side and the mask of playing channels.
//   A render walks the channels one at a time: a channel that steps passes
//   through select, sample RAM read, and mix and write back; a skipped one
//   passes through select only. The result goes into the rsp_ registers
//   once every channel has been walked and the output register is free.
//   One command is worked on at a time; req_stall is high while a render
//   is in progress or its result waits in the output register.
//   The result holds in rsp_ registers until the receiver drops rsp_stall;
//   the next command is taken in the same cycle the result leaves.
//   Reset clears all channel registers, so no channel plays; the sample
//   RAM is not cleared and must be written before it is played.
module delta_sample_channel_mixer #(
   parameter int CHANNELS    = dscm_pkg::CHANNELS_DEF,
   parameter int MEM_DEPTH   = dscm_pkg::MEM_DEPTH_DEF,
   parameter int DELTA_SHIFT = dscm_pkg::DELTA_SHIFT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic               req_side,
   input  logic [2:0]         req_channel,
   input  logic [3:0]         req_reg_select,
   input  logic [23:0]        req_reg_value,
   input  logic [15:0]        req_mem_address,
   input  logic [11:0]        req_mem_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_mixed_sample,
   output logic               rsp_out_side,
   output logic [7:0]         rsp_playing_mask
);

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int MB = (CHANNELS < dscm_pkg::MASK_BITS) ? CHANNELS : dscm_pkg::MASK_BITS;

   logic [11:0] sample_ram [MEM_DEPTH];
   logic [11:0] ram_rdata_ff;

   logic [15:0] base_ff     [CHANNELS];
   logic [23:0] length_ff   [CHANNELS];
   logic [23:0] loop_beg_ff [CHANNELS];
   logic [23:0] loop_end_ff [CHANNELS];
   logic [15:0] loop_smp_ff [CHANNELS];
   logic [23:0] pos_ff      [CHANNELS];
   logic [15:0] last_ff     [CHANNELS];
   logic [7:0]  vol_ff      [CHANNELS];
   logic [3:0]  flags_ff    [CHANNELS];

   dscm_pkg::state_type state_ff, state_in;
   logic [CW:0]         chan_ff, chan_in;
   logic                side_ff;
   logic signed [15:0]  mix_ff, mix_in;
   logic [23:0]         npos_ff;
   logic [15:0]         nlast_ff;
   logic                rsp_valid_ff;
   logic signed [15:0]  rsp_mix_ff;
   logic                rsp_side_ff;
   logic [7:0]          rsp_mask_ff;

   logic [CW-1:0] ci;
   logic [CW-1:0] wr_ci;
   logic          req_take;
   logic          out_free;
   logic          chan_used;
   logic [23:0]   pos_inc;
   logic          wrap;
   logic [23:0]   npos_calc;
   logic [AW+1:0] addr_full;
   logic [AW-1:0] rd_addr;
   logic [15:0]   delta_ext;
   logic [15:0]   smp_new;
   logic signed [23:0] prod;
   logic signed [19:0] contrib;
   logic signed [20:0] sum;
   logic signed [15:0] sum_sat;
   logic [7:0]    mask_now;
   logic          ch_valid;

   assign ci        = chan_ff[CW-1:0];
   assign wr_ci     = CW'(req_channel);
   assign ch_valid  = (chan_ff < (CW+1)'(CHANNELS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != dscm_pkg::ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   assign chan_used = flags_ff[ci][dscm_pkg::FLAG_PLAY] &&
                      (flags_ff[ci][dscm_pkg::FLAG_MONO] ||
                       (flags_ff[ci][dscm_pkg::FLAG_LEFT] == side_ff));
   assign pos_inc   = pos_ff[ci] + 24'd1;
   assign wrap      = flags_ff[ci][dscm_pkg::FLAG_LOOP] && (pos_inc >= loop_end_ff[ci]);
   assign npos_calc = wrap ? loop_beg_ff[ci] : pos_inc;

   always_comb begin
      if (flags_ff[ci][dscm_pkg::FLAG_MONO]) begin
         addr_full = (AW+2)'(base_ff[ci]) + (AW+2)'(npos_calc);
      end else begin
         addr_full = (AW+2)'(base_ff[ci]) + (AW+2)'({npos_calc, 1'b0})
                     + (AW+2)'(!flags_ff[ci][dscm_pkg::FLAG_LEFT]);
      end
   end
   assign rd_addr = addr_full[AW-1:0];

   assign delta_ext = 16'({{4{ram_rdata_ff[11]}}, ram_rdata_ff} << DELTA_SHIFT);
   assign smp_new   = nlast_ff + delta_ext;
   assign prod      = $signed(smp_new) * $signed(vol_ff[ci]);
   assign contrib   = 20'(prod >>> 4);
   assign sum       = 21'(mix_ff) + 21'(contrib);
   assign sum_sat   = (sum > 21'(dscm_pkg::SAMPLE_MAX)) ? dscm_pkg::SAMPLE_MAX :
                      (sum < 21'(dscm_pkg::SAMPLE_MIN)) ? dscm_pkg::SAMPLE_MIN : sum[15:0];

   always_comb begin
      mask_now = '0;
      for (int i = 0; i < MB; i++) begin
         mask_now[i] = flags_ff[i][dscm_pkg::FLAG_PLAY];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dscm_pkg::ST_IDLE: begin
            if (req_take && req_opcode == dscm_pkg::OP_RENDER) begin
               state_in = dscm_pkg::ST_CHAN;
            end
         end
         dscm_pkg::ST_CHAN: begin
            if (!ch_valid) begin
               state_in = dscm_pkg::ST_DONE;
            end else if (chan_used) begin
               state_in = dscm_pkg::ST_READ;
            end
         end
         dscm_pkg::ST_READ: state_in = dscm_pkg::ST_MIX;
         dscm_pkg::ST_MIX:  state_in = dscm_pkg::ST_CHAN;
         dscm_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = dscm_pkg::ST_IDLE;
            end
         end
         default: state_in = dscm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      chan_in = chan_ff;
      mix_in  = mix_ff;
      case (state_ff)
         dscm_pkg::ST_IDLE: begin
            chan_in = '0;
            mix_in  = '0;
         end
         dscm_pkg::ST_CHAN: begin
            if (ch_valid && !chan_used) begin
               chan_in = chan_ff + 1'b1;
            end
         end
         dscm_pkg::ST_MIX: begin
            chan_in = chan_ff + 1'b1;
            mix_in  = sum_sat;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take && req_opcode == dscm_pkg::OP_MEM_WRITE) begin
         sample_ram[AW'(req_mem_address)] <= req_mem_data;
      end
      ram_rdata_ff <= sample_ram[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == dscm_pkg::ST_CHAN) begin
         npos_ff  <= npos_calc;
         nlast_ff <= wrap ? loop_smp_ff[ci] : last_ff[ci];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dscm_pkg::ST_IDLE;
         chan_ff      <= '0;
         mix_ff       <= '0;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            base_ff[i]     <= '0;
            length_ff[i]   <= '0;
            loop_beg_ff[i] <= '0;
            loop_end_ff[i] <= '0;
            loop_smp_ff[i] <= '0;
            pos_ff[i]      <= '0;
            last_ff[i]     <= '0;
            vol_ff[i]      <= '0;
            flags_ff[i]    <= '0;
         end
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         mix_ff   <= mix_in;
         if (req_take) begin
            side_ff <= req_side;
         end
         if (req_take && req_opcode == dscm_pkg::OP_REG_WRITE &&
             (int'(req_channel) < CHANNELS)) begin
            case (req_reg_select)
               dscm_pkg::REG_BASE:     base_ff[wr_ci]     <= req_reg_value[15:0];
               dscm_pkg::REG_COUNT:    length_ff[wr_ci]   <= req_reg_value;
               dscm_pkg::REG_LOOP_BEG: loop_beg_ff[wr_ci] <= req_reg_value;
               dscm_pkg::REG_LOOP_END: loop_end_ff[wr_ci] <= req_reg_value;
               dscm_pkg::REG_LOOP_SMP: loop_smp_ff[wr_ci] <= req_reg_value[15:0];
               dscm_pkg::REG_POSITION: pos_ff[wr_ci]      <= req_reg_value;
               dscm_pkg::REG_LAST_SMP: last_ff[wr_ci]     <= req_reg_value[15:0];
               dscm_pkg::REG_VOLUME:   vol_ff[wr_ci]      <= req_reg_value[7:0];
               dscm_pkg::REG_FLAGS:    flags_ff[wr_ci]    <= req_reg_value[3:0];
               default: ;
            endcase
         end
         if (state_ff == dscm_pkg::ST_MIX) begin
            pos_ff[ci]  <= npos_ff;
            last_ff[ci] <= smp_new;
            if (npos_ff >= length_ff[ci]) begin
               flags_ff[ci][dscm_pkg::FLAG_PLAY] <= 1'b0;
            end
         end
         if (state_ff == dscm_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == dscm_pkg::ST_DONE && out_free) begin
         rsp_mix_ff  <= mix_ff;
         rsp_side_ff <= side_ff;
         rsp_mask_ff <= mask_now;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_mix_ff;
   assign rsp_out_side     = rsp_side_ff;
   assign rsp_playing_mask = rsp_mask_ff;

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != dscm_pkg::ST_IDLE) |-> !req_take)
      else $error("command taken during render");

   a_render_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_opcode == dscm_pkg::OP_RENDER) |=> (state_ff == dscm_pkg::ST_CHAN))
      else $error("render did not start");

   a_read_then_mix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dscm_pkg::ST_READ) |=> (state_ff == dscm_pkg::ST_MIX))
      else $error("mix step skipped");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dscm_pkg::ST_DONE && out_free) |=> rsp_valid)
      else $error("render result lost");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the delta sample channel mixer: directed and random beats checked against a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam logic [3:0] REG_NONE_LO   = 4'd9;
   localparam logic [3:0] REG_NONE_HI   = 4'd15;
   localparam int         N_CHAN        = 8;

   typedef struct packed {
      logic signed [15:0] mixed;
      logic               side;
      logic [7:0]         mask;
   } mix_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = dscm_pkg::OP_MEM_WRITE;
   logic               req_side = 1'b0;
   logic [2:0]         req_channel = '0;
   logic [3:0]         req_reg_select = '0;
   logic [23:0]        req_reg_value = '0;
   logic [15:0]        req_mem_address = '0;
   logic [11:0]        req_mem_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_mixed_sample;
   logic               rsp_out_side;
   logic [7:0]         rsp_playing_mask;

   logic [11:0]  sample_words [int unsigned];
   logic [15:0]  ch_base [N_CHAN];
   logic [23:0]  ch_length [N_CHAN];
   logic [23:0]  ch_loop_beg [N_CHAN];
   logic [23:0]  ch_loop_end [N_CHAN];
   logic [15:0]  ch_loop_smp [N_CHAN];
   logic [23:0]  ch_pos [N_CHAN];
   logic [15:0]  ch_last [N_CHAN];
   logic [7:0]   ch_volume [N_CHAN];
   logic [3:0]   ch_flags [N_CHAN];

   mix_result_type pending_mixes [$];
   int          mismatches = 0;
   int          cyc = 0;
   int          hold_until = 0;
   int          burst_left = 8;

   delta_sample_channel_mixer DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // receiver: long hold when asked, otherwise one of four stall patterns picked by cyc[9:8]
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc < hold_until) begin
         rsp_stall <= 1'b1;
      end else begin
         case (cyc[9:8])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= cyc[2];
         endcase
      end
   end

   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_mixes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: %0d side %0d mask %h",
                        rsp_mixed_sample, rsp_out_side, rsp_playing_mask);
         end else begin
            want = pending_mixes.pop_front();
            if (rsp_mixed_sample !== want.mixed || rsp_out_side !== want.side ||
                rsp_playing_mask !== want.mask) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%h got %0d/%0d/%h",
                           want.mixed, want.side, want.mask,
                           rsp_mixed_sample, rsp_out_side, rsp_playing_mask);
            end
         end
      end
   end

   function automatic bit channel_steps(int c, logic sd);
      return ch_flags[c][dscm_pkg::FLAG_PLAY] &&
             (ch_flags[c][dscm_pkg::FLAG_MONO] || ch_flags[c][dscm_pkg::FLAG_LEFT] == sd);
   endfunction

   function automatic logic [23:0] stepped_pos(int c);
      logic [23:0] p;
      p = ch_pos[c] + 24'd1;
      if (ch_flags[c][dscm_pkg::FLAG_LOOP] && p >= ch_loop_end[c])
         p = ch_loop_beg[c];
      return p;
   endfunction

   function automatic logic [15:0] delta_addr(int c, logic [23:0] p);
      if (ch_flags[c][dscm_pkg::FLAG_MONO])
         return ch_base[c] + p[15:0];
      return ch_base[c] + {p[14:0], 1'b0} + (ch_flags[c][dscm_pkg::FLAG_LEFT] ? 16'd0 : 16'd1);
   endfunction

   task automatic predict_mix(input logic sd);
      int          mix, prod;
      logic [23:0] p;
      logic [11:0] d;
      logic [15:0] inc;
      mix_result_type r;
      mix = 0;
      r.mask = '0;
      for (int c = 0; c < N_CHAN; c++) begin
         if (!channel_steps(c, sd))
            continue;
         p = ch_pos[c] + 24'd1;
         if (ch_flags[c][dscm_pkg::FLAG_LOOP] && p >= ch_loop_end[c]) begin
            p = ch_loop_beg[c];
            ch_last[c] = ch_loop_smp[c];
         end
         ch_pos[c] = p;
         d = sample_words[delta_addr(c, p)];
         inc = {{4{d[11]}}, d} << dscm_pkg::DELTA_SHIFT_DEF;
         ch_last[c] = ch_last[c] + inc;
         prod = $signed(ch_last[c]) * $signed(ch_volume[c]);
         mix = mix + (prod >>> 4);
         if (mix > dscm_pkg::SAMPLE_MAX)
            mix = dscm_pkg::SAMPLE_MAX;
         else if (mix < dscm_pkg::SAMPLE_MIN)
            mix = dscm_pkg::SAMPLE_MIN;
         if (ch_pos[c] >= ch_length[c])
            ch_flags[c][dscm_pkg::FLAG_PLAY] = 1'b0;
      end
      for (int c = 0; c < N_CHAN; c++)
         r.mask[c] = ch_flags[c][dscm_pkg::FLAG_PLAY];
      r.mixed = mix[15:0];
      r.side = sd;
      pending_mixes.push_back(r);
   endtask

   task automatic apply_command(input logic [1:0] op, input logic sd, input logic [2:0] ch,
                                input logic [3:0] sel, input logic [23:0] val,
                                input logic [15:0] ad, input logic [11:0] dt);
      case (op)
         dscm_pkg::OP_MEM_WRITE: sample_words[ad] = dt;
         dscm_pkg::OP_REG_WRITE: begin
            case (sel)
               dscm_pkg::REG_BASE:     ch_base[ch] = val[15:0];
               dscm_pkg::REG_COUNT:    ch_length[ch] = val;
               dscm_pkg::REG_LOOP_BEG: ch_loop_beg[ch] = val;
               dscm_pkg::REG_LOOP_END: ch_loop_end[ch] = val;
               dscm_pkg::REG_LOOP_SMP: ch_loop_smp[ch] = val[15:0];
               dscm_pkg::REG_POSITION: ch_pos[ch] = val;
               dscm_pkg::REG_LAST_SMP: ch_last[ch] = val[15:0];
               dscm_pkg::REG_VOLUME:   ch_volume[ch] = val[7:0];
               dscm_pkg::REG_FLAGS:    ch_flags[ch] = val[3:0];
               default: ;
            endcase
         end
         dscm_pkg::OP_RENDER: predict_mix(sd);
         default: ;
      endcase
   endtask

   task automatic send_beat(input logic [1:0] op, input logic sd, input logic [2:0] ch,
                            input logic [3:0] sel, input logic [23:0] val,
                            input logic [15:0] ad, input logic [11:0] dt);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_side <= sd;
      req_channel <= ch;
      req_reg_select <= sel;
      req_reg_value <= val;
      req_mem_address <= ad;
      req_mem_data <= dt;
      do @(posedge clock); while (req_stall);
      apply_command(op, sd, ch, sel, val, ad, dt);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic mem_write(input logic [15:0] ad, input logic [11:0] dt);
      send_beat(dscm_pkg::OP_MEM_WRITE, 1'($urandom_range(0, 1)), 3'($urandom), 4'($urandom),
                24'($urandom), ad, dt);
   endtask

   task automatic reg_write(input logic [2:0] ch, input logic [3:0] sel, input logic [23:0] val);
      send_beat(dscm_pkg::OP_REG_WRITE, 1'($urandom_range(0, 1)), ch, sel, val,
                16'($urandom), 12'($urandom));
   endtask

   // fill every delta word the render is about to read that has never been written
   task automatic render(input logic sd);
      logic [15:0] a;
      for (int c = 0; c < N_CHAN; c++) begin
         if (channel_steps(c, sd)) begin
            a = delta_addr(c, stepped_pos(c));
            if (!sample_words.exists(a))
               mem_write(a, 12'($urandom));
         end
      end
      send_beat(dscm_pkg::OP_RENDER, sd, 3'($urandom), 4'($urandom), 24'($urandom),
                16'($urandom), 12'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_mixes.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic test_idle_render();
      render(1'b1);
      render(1'b0);
   endtask

   task automatic test_mono_extremes();
      mem_write(16'h0000, 12'h7FF);
      mem_write(16'h0001, 12'h800);
      mem_write(16'hFFFF, 12'hFFF);
      reg_write(3'd0, dscm_pkg::REG_BASE, 24'h000000);
      reg_write(3'd0, dscm_pkg::REG_COUNT, 24'h000003);
      reg_write(3'd0, dscm_pkg::REG_POSITION, 24'hFFFFFF);
      reg_write(3'd0, dscm_pkg::REG_VOLUME, 24'h00007F);
      reg_write(3'd0, dscm_pkg::REG_FLAGS, 24'h000006);
      repeat (4) render(1'b1);
   endtask

   task automatic test_stereo_loop();
      reg_write(3'd1, dscm_pkg::REG_BASE, 24'h00FFFE);
      reg_write(3'd1, dscm_pkg::REG_COUNT, 24'hFFFFFF);
      reg_write(3'd1, dscm_pkg::REG_VOLUME, 24'h000080);
      reg_write(3'd1, dscm_pkg::REG_FLAGS, 24'h00000B);
      reg_write(3'd1, dscm_pkg::REG_LOOP_BEG, 24'h000000);
      reg_write(3'd1, dscm_pkg::REG_LOOP_END, 24'h000002);
      reg_write(3'd1, dscm_pkg::REG_LOOP_SMP, 24'h008000);
      reg_write(3'd2, dscm_pkg::REG_BASE, 24'hFFFFFF);
      reg_write(3'd2, dscm_pkg::REG_COUNT, 24'h000005);
      reg_write(3'd2, dscm_pkg::REG_VOLUME, 24'h000010);
      reg_write(3'd2, dscm_pkg::REG_FLAGS, 24'h000003);
      reg_write(3'd2, dscm_pkg::REG_LOOP_END, 24'h000003);
      repeat (3) begin
         render(1'b1);
         render(1'b0);
      end
   endtask

   task automatic test_saturation();
      mem_write(16'h1000, 12'h000);
      for (int c = 0; c < N_CHAN; c++) begin
         reg_write(3'(c), dscm_pkg::REG_BASE, 24'h000FFF);
         reg_write(3'(c), dscm_pkg::REG_POSITION, 24'h000000);
         reg_write(3'(c), dscm_pkg::REG_COUNT, 24'h000100);
         reg_write(3'(c), dscm_pkg::REG_LAST_SMP, 24'h007FF0);
         reg_write(3'(c), dscm_pkg::REG_VOLUME, 24'h00007F);
         reg_write(3'(c), dscm_pkg::REG_FLAGS, 24'h000006);
      end
      render(1'b0);
      for (int c = 0; c < N_CHAN; c++) begin
         reg_write(3'(c), dscm_pkg::REG_POSITION, 24'h000000);
         reg_write(3'(c), dscm_pkg::REG_VOLUME, 24'h000080);
      end
      render(1'b1);
   endtask

   task automatic test_ignored_commands();
      send_beat(OP_UNUSED, 1'b1, 3'd7, dscm_pkg::REG_FLAGS, 24'hFFFFFF, 16'hFFFF, 12'hFFF);
      reg_write(3'd7, REG_NONE_LO, 24'hFFFFFF);
      reg_write(3'd7, REG_NONE_HI, 24'h000000);
      render(1'b0);
   endtask

   function automatic logic [23:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'hFFFFFF - 24'($urandom_range(0, 8));
         default: return 24'($urandom_range(0, 48));
      endcase
   endfunction

   task automatic test_random_mix(input int beats);
      int r;
      for (int i = 0; i < beats; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30)
            reg_write(3'($urandom),
                      (r < 3) ? 4'($urandom_range(REG_NONE_LO, REG_NONE_HI)) :
                                4'($urandom_range(dscm_pkg::REG_BASE, dscm_pkg::REG_FLAGS)),
                      pick_value());
         else if (r < 40)
            mem_write(16'($urandom), 12'($urandom));
         else if (r < 42)
            send_beat(OP_UNUSED, 1'($urandom), 3'($urandom), 4'($urandom), 24'($urandom),
                      16'($urandom), 12'($urandom));
         else
            render(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_backpressure();
      hold_until = cyc + 400;
      repeat (20) render(1'($urandom_range(0, 1)));
      drain();
   endtask

   initial begin
      for (int c = 0; c < N_CHAN; c++) begin
         ch_base[c] = '0; ch_length[c] = '0; ch_loop_beg[c] = '0; ch_loop_end[c] = '0;
         ch_loop_smp[c] = '0; ch_pos[c] = '0; ch_last[c] = '0; ch_volume[c] = '0;
         ch_flags[c] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_render();
      test_mono_extremes();
      test_stereo_loop();
      test_saturation();
      test_ignored_commands();
      drain();
      test_random_mix(500);
      test_backpressure();
      test_random_mix(500);
      drain();
      if (mismatches == 0 && pending_mixes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== delta_sample_channel_mixer.f =====
rtl/dscm_pkg.sv
rtl/delta_sample_channel_mixer.sv
bench/tb_top.sv
